/* design/ism_pkg.sv */
// Shared types and constants for the Ising Metropolis spin update engine.
package ism_pkg;

  localparam int OPCODE_W = 3;
  localparam int SITE_W   = 6;
  localparam int SLOT_W   = 4;
  localparam int LOAD_W   = 6;
  localparam int RAND_W   = 32;
  localparam int RATIO_W  = 32;
  localparam int EC_W     = 7;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 32'hFFFF_FFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_SPIN = 3'd0,
    OP_WR_NB   = 3'd1,
    OP_WR_DEG  = 3'd2,
    OP_UPDATE  = 3'd3,
    OP_RD_SPIN = 3'd4
  } opcode_e;

endpackage

/* design/ising_metropolis_spin_update.sv */
// Metropolis spin-flip engine for an Ising model on a bounded neighbor table.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+------------------------------------------
//   in      | in  | in_valid_i / in_stall_o   | opcode, site, slot, load_value, random_word
//   out     | out | out_valid_o / out_stall_i | spin_value, flipped, energy_change
//   cfg     | in  | cfg_we_i (no wait)        | cfg_wdata_i -> flip_ratio
//
// After reset a clearing pass over every site zeroes the spin and degree
// memories; no item is taken meanwhile, configuration writes are.
// Load and read items pass through the fetch and finish steps to the result register.
// An update steps through fetch, self read, neighbor sum, decide, power (skipped
// unless dE is positive) and finish: one neighbor per cycle through the two
// chained memory reads, then one 32x32 multiply per cycle for the acceptance power.
// A result waits in the output register while out_stall_i is high; the next
// item may be accepted meanwhile and holds in its last step until the register frees.
module ising_metropolis_spin_update #(
  parameter int MAX_SITES  = 64,
  parameter int MAX_DEGREE = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [ism_pkg::RATIO_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ism_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [ism_pkg::SITE_W-1:0]     site_i,
  input  logic [ism_pkg::SLOT_W-1:0]     slot_i,
  input  logic [ism_pkg::LOAD_W-1:0]     load_value_i,
  input  logic [ism_pkg::RAND_W-1:0]     random_word_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           spin_value_o,
  output logic                           flipped_o,
  output logic signed [ism_pkg::EC_W-1:0] energy_change_o
);
  import ism_pkg::*;

  localparam int SiteW   = $clog2(MAX_SITES);
  localparam int DegW    = $clog2(MAX_DEGREE + 1);
  localparam int NbSlotW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int SumW    = DegW + 1;
  localparam int NbDepth = MAX_SITES * (2 ** NbSlotW);
  localparam int NbAddrW = SiteW + NbSlotW;
  localparam int WrapN   = 2 ** SITE_W;

  localparam logic [LOAD_W:0]    MaxDegL  = (LOAD_W + 1)'(MAX_DEGREE);
  localparam logic [DegW-1:0]    MaxDegD  = DegW'(MAX_DEGREE);
  localparam logic [SiteW-1:0]   LastSite = SiteW'(MAX_SITES - 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_FETCH  = 8'b0000_0100,
    S_SELF   = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_POW    = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  // Site wrap table: any 6-bit index modulo MAX_SITES.
  logic [SiteW-1:0] wrap_lut [WrapN];
  for (genvar g = 0; g < WrapN; g++) begin : g_wrap
    assign wrap_lut[g] = SiteW'(g % MAX_SITES);
  end

  // Memories
  logic                spin_mem [MAX_SITES];
  logic [DegW-1:0]     deg_mem  [MAX_SITES];
  logic [SiteW-1:0]    nb_mem   [NbDepth];

  logic                spin_we, spin_wdata, spin_rd_q;
  logic [SiteW-1:0]    spin_waddr, spin_raddr;
  logic                deg_we;
  logic [DegW-1:0]     deg_wdata, deg_rd_q;
  logic [SiteW-1:0]    deg_waddr;
  logic                nb_we;
  logic [NbAddrW-1:0]  nb_waddr, nb_raddr;
  logic [SiteW-1:0]    nb_rd_q;

  // Control state
  state_e              state_q, state_d;
  logic [SiteW-1:0]    clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  logic                v1_q, v1_d, v2_q, v2_d;
  logic [RATIO_W-1:0]  ratio_q;

  // Item payload and datapath
  opcode_e             op_q, op_d;
  logic [SiteW-1:0]    site_q, site_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [LOAD_W-1:0]   val_q, val_d;
  logic [RAND_W-1:0]   rnd_q, rnd_d;
  logic                self_q, self_d;
  logic [DegW-1:0]     deg_q, deg_d;
  logic [DegW-1:0]     i_q, i_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [SumW-1:0] e_q, e_d;
  logic [RATIO_W-1:0]  p_q, p_d;
  logic [DegW-1:0]     m_q, m_d;
  logic                flip_q, flip_d;
  logic                spin_out_q, spin_out_d;
  logic                flipped_q, flipped_d;
  logic signed [EC_W-1:0] ec_q, ec_d;

  logic                   in_accept, out_free, issue;
  logic [2*RATIO_W-1:0]   prod;
  logic signed [SumW:0]   de_full;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign issue     = (i_q < deg_q);
  assign prod      = {{RATIO_W{1'b0}}, p_q} * {{RATIO_W{1'b0}}, ratio_q};
  assign de_full   = {e_q, 1'b0};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    op_d        = op_q;
    site_d      = site_q;
    slot_d      = slot_q;
    val_d       = val_q;
    rnd_d       = rnd_q;
    self_d      = self_q;
    deg_d       = deg_q;
    i_d         = i_q;
    sum_d       = sum_q;
    e_d         = e_q;
    p_d         = p_q;
    m_d         = m_q;
    flip_d      = flip_q;
    spin_out_d  = spin_out_q;
    flipped_d   = flipped_q;
    ec_d        = ec_q;

    spin_we     = 1'b0;
    spin_waddr  = site_q;
    spin_wdata  = 1'b0;
    spin_raddr  = site_q;
    deg_we      = 1'b0;
    deg_waddr   = site_q;
    deg_wdata   = '0;
    nb_we       = 1'b0;
    nb_waddr    = {site_q, NbSlotW'(slot_q)};
    nb_raddr    = {site_q, i_q[NbSlotW-1:0]};

    unique case (state_q)
      S_CLEAR: begin
        // zero one site of spin and degree per cycle
        spin_we    = 1'b1;
        spin_waddr = clr_q;
        deg_we     = 1'b1;
        deg_waddr  = clr_q;
        clr_d      = clr_q + SiteW'(1);
        if (clr_q == LastSite) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          op_d    = opcode_e'(opcode_i);
          site_d  = wrap_lut[site_i];
          slot_d  = slot_i;
          val_d   = load_value_i;
          rnd_d   = random_word_i;
          flip_d  = 1'b0;
          e_d     = '0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        // perform loads; spin and degree of the site are read here
        spin_wdata = val_q[0];
        spin_we    = (op_q == OP_WR_SPIN);
        nb_we      = (op_q == OP_WR_NB) && ((LOAD_W + 1)'(slot_q) < MaxDegL);
        deg_we     = (op_q == OP_WR_DEG);
        deg_wdata  = ({1'b0, val_q} > MaxDegL) ? MaxDegD : DegW'(val_q);
        state_d    = (op_q == OP_UPDATE) ? S_SELF : S_FINISH;
      end
      S_SELF: begin
        self_d  = spin_rd_q;
        deg_d   = deg_rd_q;
        i_d     = '0;
        sum_d   = '0;
        state_d = S_SUM;
      end
      S_SUM: begin
        // issue neighbor reads, chase each into the spin memory, accumulate
        spin_raddr = nb_rd_q;
        v1_d       = issue;
        v2_d       = v1_q;
        if (issue) begin
          i_d = i_q + DegW'(1);
        end
        if (v2_q) begin
          sum_d = spin_rd_q ? (sum_q + SumW'(1)) : (sum_q - SumW'(1));
        end
        if (!issue && !v1_q && !v2_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        e_d = self_q ? sum_q : -sum_q;
        if (e_d[SumW-1] || (e_d == '0)) begin
          flip_d  = 1'b1;
          state_d = S_FINISH;
        end else begin
          p_d     = ratio_q;
          m_d     = e_d[DegW-1:0] - DegW'(1);
          state_d = S_POW;
        end
      end
      S_POW: begin
        if (m_q == '0) begin
          flip_d  = (rnd_q < p_q);
          state_d = S_FINISH;
        end else begin
          p_d = prod[2*RATIO_W-1:RATIO_W];
          m_d = m_q - DegW'(1);
        end
      end
      S_FINISH: begin
        // hold until the output register frees, then commit and report
        if (out_free) begin
          spin_we     = (op_q == OP_UPDATE) && flip_q;
          spin_wdata  = !self_q;
          out_valid_d = 1'b1;
          flipped_d   = flip_q;
          ec_d        = EC_W'(de_full);
          if (op_q == OP_UPDATE) begin
            spin_out_d = self_q ^ flip_q;
          end else if (op_q == OP_WR_SPIN) begin
            spin_out_d = val_q[0];
          end else begin
            spin_out_d = spin_rd_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      ratio_q     <= RATIO_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    site_q     <= site_d;
    slot_q     <= slot_d;
    val_q      <= val_d;
    rnd_q      <= rnd_d;
    self_q     <= self_d;
    deg_q      <= deg_d;
    i_q        <= i_d;
    sum_q      <= sum_d;
    e_q        <= e_d;
    p_q        <= p_d;
    m_q        <= m_d;
    flip_q     <= flip_d;
    spin_out_q <= spin_out_d;
    flipped_q  <= flipped_d;
    ec_q       <= ec_d;
  end

  // Spin memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (spin_we) begin
      spin_mem[spin_waddr] <= spin_wdata;
    end
    spin_rd_q <= spin_mem[spin_raddr];
  end

  // Degree memory
  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rd_q <= deg_mem[site_q];
  end

  // Neighbor memory, entries stored already wrapped to a site index
  always_ff @(posedge clk_i) begin
    if (nb_we) begin
      nb_mem[nb_waddr] <= wrap_lut[val_q];
    end
    nb_rd_q <= nb_mem[nb_raddr];
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign spin_value_o    = spin_out_q;
  assign flipped_o       = flipped_q;
  assign energy_change_o = ec_q;

  // A new result appears only out of the finishing step.
  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside finish step");

  // The neighbor counter never passes the degree.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (i_q <= deg_q))
    else $error("neighbor count past degree");

  // The partial sum never exceeds the neighbors issued so far.
  a_sum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> ((sum_q <= $signed({1'b0, i_q}))
                            && (-sum_q <= $signed({1'b0, i_q}))))
    else $error("partial sum out of range");

  // Each multiply step counts the remaining power down by one.
  a_pow_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_POW) && (m_q != '0)) |=> (m_q == $past(m_q) - DegW'(1)))
    else $error("power counter slipped");

endmodule
